[hw/rtl/mmcrd_pkg.sv]
package mmcrd_pkg;

  localparam int BLOCK_BYTES_DEF = 512;
  localparam int WAKE_CLOCKS_DEF = 80;

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_BYTE  = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_WAKE  = 4'd1,
    PH_CMD0  = 4'd2,
    PH_CMD1  = 4'd3,
    PH_RWAIT = 4'd4,
    PH_CMD17 = 4'd5,
    PH_TOKEN = 4'd6,
    PH_DATA  = 4'd7,
    PH_CRC   = 4'd8
  } phase_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INIT_TMO = 2'd1;
  localparam logic [1:0] ST_TOK_TMO  = 2'd2;

  localparam logic [1:0] REG_INIT_TRY  = 2'd0;
  localparam logic [1:0] REG_TOKEN_LIM = 2'd1;
  localparam logic [1:0] REG_WAIT      = 2'd2;

  localparam logic [7:0] TOKEN_START = 8'hfe;

  // Input beat after the front end has classified it.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [7:0]  card_byte;
  } item_t;

  // Result fields in tdata order.
  typedef struct packed {
    logic [1:0] status;
    logic       done_res;
    logic       data_last;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       select_active;
    logic [7:0] send_byte;
    logic       send_valid;
  } res_t;

  function automatic logic [7:0] go_idle_byte(input logic [3:0] i);
    case (i)
      4'd0:    go_idle_byte = 8'h40;
      4'd5:    go_idle_byte = 8'h95;
      4'd1, 4'd2, 4'd3, 4'd4: go_idle_byte = 8'h00;
      default: go_idle_byte = 8'hff;
    endcase
  endfunction

  function automatic logic [7:0] op_cond_byte(input logic [3:0] i);
    case (i)
      4'd0:    op_cond_byte = 8'h41;
      4'd5:    op_cond_byte = 8'hf9;
      4'd1, 4'd2, 4'd3, 4'd4: op_cond_byte = 8'h00;
      default: op_cond_byte = 8'hff;
    endcase
  endfunction

endpackage

[hw/rtl/mmc_spi_init_and_block_read.sv]
// A result beat is held in the output register and shown on out_tvalid after its
// input beat has passed through the two-entry front queue and the sequencer.
// Throughput: one input beat per cycle unless a side stalls; the two-entry front
// queue and the output register let either side stall without losing a beat.
// Reset (rst_n low, synchronous) idles the sequencer, releases select and
// loads the limit registers with 200, 1024 and 10.
module mmc_spi_init_and_block_read #(
  parameter int BLOCK_BYTES = mmcrd_pkg::BLOCK_BYTES_DEF,
  parameter int WAKE_CLOCKS = mmcrd_pkg::WAKE_CLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // kind[1:0], block_address[33:2], card_byte[41:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  // send_valid, send_byte, select_active, data_valid, data_byte, data_last,
  // done_res, status (from bit 0 up)
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  import mmcrd_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  mmcrd_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_ready, .q_item
  );

  mmcrd_seq #(.BLOCK_BYTES(BLOCK_BYTES), .WAKE_CLOCKS(WAKE_CLOCKS)) u_seq (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .cfg_we, .cfg_index, .cfg_wdata,
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule

[hw/rtl/mmcrd_front.sv]
module mmcrd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [47:0]     in_tdata,
  output logic            q_valid,
  input  logic            q_ready,
  output mmcrd_pkg::item_t q_item
);
  import mmcrd_pkg::*;

  // Two-entry queue between input and sequencer.
  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push, pop;
  item_t      item;

  always_comb begin
    item.kind      = kind_t'(in_tdata[1:0]);
    item.addr      = in_tdata[33:2];
    item.card_byte = in_tdata[41:34];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= item;
  end

endmodule

[hw/rtl/mmcrd_seq.sv]
module mmcrd_seq #(
  parameter int BLOCK_BYTES = mmcrd_pkg::BLOCK_BYTES_DEF,
  parameter int WAKE_CLOCKS = mmcrd_pkg::WAKE_CLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  mmcrd_pkg::item_t q_item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [11:0]      cfg_wdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata
);
  import mmcrd_pkg::*;

  localparam int WAKE_BYTES = (WAKE_CLOCKS + 7) / 8;
  localparam logic [9:0] WAKE_LAST = 10'(WAKE_BYTES - 1);
  localparam logic [9:0] BLK_LAST  = 10'(BLOCK_BYTES - 1);

  phase_t      phase_r, phase_nxt;
  logic [9:0]  bc_r, bc_nxt;
  logic [11:0] try_r, try_nxt;
  logic [7:0]  wait_r, wait_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        sel_r, sel_nxt;
  logic        r1z_r, r1z_nxt;
  logic [9:0]  lim_init_r;
  logic [11:0] lim_tok_r;
  logic [7:0]  lim_wait_r;

  logic        ov_r;
  res_t        od_r;
  logic        emit;
  res_t        res;
  logic        step;

  // Output register; a new beat may be taken while it is drained.
  assign q_ready    = !ov_r || out_tready;
  assign step       = q_valid && q_ready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, od_r};

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    try_nxt   = try_r;
    wait_nxt  = wait_r;
    addr_nxt  = addr_r;
    sel_nxt   = sel_r;
    r1z_nxt   = r1z_r;
    emit      = 1'b0;
    res       = '0;
    res.send_valid = 1'b1;
    res.send_byte  = 8'hff;
    case (q_item.kind)
      KIND_INIT: begin
        sel_nxt = 1'b0; phase_nxt = PH_WAKE; bc_nxt = '0; try_nxt = '0; emit = 1'b1;
      end
      KIND_READ: begin
        addr_nxt = q_item.addr; phase_nxt = PH_CMD17; bc_nxt = '0;
        res.send_byte = 8'h51; emit = 1'b1;
      end
      KIND_BYTE: begin
        case (phase_r)
          PH_WAKE: begin
            emit = 1'b1;
            if (bc_r < WAKE_LAST) bc_nxt = bc_r + 10'd1;
            else begin
              sel_nxt = 1'b1; phase_nxt = PH_CMD0; bc_nxt = '0;
              res.send_byte = go_idle_byte(4'd0);
            end
          end
          PH_CMD0: begin
            emit = 1'b1;
            if (bc_r < 10'd8) begin
              bc_nxt = bc_r + 10'd1;
              res.send_byte = go_idle_byte(bc_nxt[3:0]);
            end else begin
              try_nxt = '0; phase_nxt = PH_CMD1; bc_nxt = '0; r1z_nxt = 1'b0;
              res.send_byte = op_cond_byte(4'd0);
            end
          end
          PH_CMD1: begin
            if (bc_r == 10'd7) r1z_nxt = (q_item.card_byte == 8'h00);
            if (bc_r < 10'd8) begin
              emit = 1'b1;
              bc_nxt = bc_r + 10'd1;
              res.send_byte = op_cond_byte(bc_nxt[3:0]);
            end else if (r1z_r || try_r >= {2'b00, lim_init_r}) begin
              emit = 1'b1; phase_nxt = PH_IDLE;
              res.send_valid = 1'b0; res.done_res = 1'b1;
              res.status = r1z_r ? ST_OK : ST_INIT_TMO;
            end else begin
              try_nxt = try_r + 12'd1; phase_nxt = PH_RWAIT; wait_nxt = '0;
            end
          end
          PH_CMD17: begin
            emit = 1'b1;
            if (bc_r < 10'd6) begin
              bc_nxt = bc_r + 10'd1;
              case (bc_nxt[2:0])
                3'd1:    res.send_byte = addr_r[31:24];
                3'd2:    res.send_byte = addr_r[23:16];
                3'd3:    res.send_byte = addr_r[15:8];
                3'd4:    res.send_byte = addr_r[7:0];
                3'd5:    res.send_byte = 8'h01;
                default: res.send_byte = 8'hff;
              endcase
            end else begin
              phase_nxt = PH_TOKEN; try_nxt = '0;
            end
          end
          PH_TOKEN: begin
            emit = 1'b1;
            if (q_item.card_byte == TOKEN_START) begin
              phase_nxt = PH_DATA; bc_nxt = '0;
            end else if (try_r >= lim_tok_r) begin
              phase_nxt = PH_IDLE;
              res.send_valid = 1'b0; res.done_res = 1'b1; res.status = ST_TOK_TMO;
            end else try_nxt = try_r + 12'd1;
          end
          PH_DATA: begin
            emit = 1'b1;
            res.data_valid = 1'b1;
            res.data_byte  = q_item.card_byte;
            if (bc_r >= BLK_LAST) begin
              res.data_last = 1'b1; phase_nxt = PH_CRC; bc_nxt = '0;
            end else bc_nxt = bc_r + 10'd1;
          end
          PH_CRC: begin
            emit = 1'b1;
            if (bc_r == 10'd0) bc_nxt = 10'd1;
            else begin
              phase_nxt = PH_IDLE;
              res.send_valid = 1'b0; res.done_res = 1'b1; res.status = ST_OK;
            end
          end
          default: emit = 1'b0;
        endcase
      end
      default: begin
        if (phase_r == PH_RWAIT) begin
          if (wait_r != 8'hff) wait_nxt = wait_r + 8'd1;
          if (wait_nxt >= lim_wait_r) begin
            emit = 1'b1; phase_nxt = PH_CMD1; bc_nxt = '0; r1z_nxt = 1'b0;
            res.send_byte = op_cond_byte(4'd0);
          end
        end
      end
    endcase
    // Select goes out as it stands after this beat.
    res.select_active = sel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; bc_r <= '0; try_r <= '0; wait_r <= '0;
      addr_r <= '0; sel_r <= 1'b0; r1z_r <= 1'b0; ov_r <= 1'b0;
      lim_init_r <= 10'd200; lim_tok_r <= 12'd1024; lim_wait_r <= 8'd10;
    end else begin
      if (step) begin
        phase_r <= phase_nxt; bc_r <= bc_nxt; try_r <= try_nxt; wait_r <= wait_nxt;
        addr_r <= addr_nxt; sel_r <= sel_nxt; r1z_r <= r1z_nxt;
        ov_r <= emit;
      end else if (out_tready) ov_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_TRY:  lim_init_r <= cfg_wdata[9:0];
          REG_TOKEN_LIM: lim_tok_r  <= cfg_wdata;
          REG_WAIT:      lim_wait_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) od_r <= res;
  end

endmodule

[hw/rtl/mmcrd_checker.sv]
module mmcrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_done_nosend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> !out_tdata[0] && out_tdata[8:1] == 8'hff)
    else $error("finished beat requests an exchange");

  a_data_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[0] && !out_tdata[20])
    else $error("data beat without exchange");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tdata[10])
    else $error("last flag without data");
endmodule

bind mmc_spi_init_and_block_read mmcrd_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
